// ----- sv/arci_pkg.sv -----
package arci_pkg;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_ONE   = 8'h31;
    localparam logic [7:0] C_UPPER = 8'h37;
    localparam logic [7:0] C_E     = 8'h45;
    localparam logic [7:0] C_F     = 8'h46;
    localparam logic [7:0] C_N     = 8'h4E;
    localparam logic [7:0] C_O     = 8'h4F;
    localparam logic [7:0] C_R     = 8'h52;
    localparam logic [7:0] C_S     = 8'h53;
    localparam logic [7:0] C_T     = 8'h54;
    localparam logic [7:0] HEX_LO  = 8'h11;
    localparam logic [7:0] HEX_HI  = 8'h16;
    localparam logic [7:0] ALL_OFF = 8'hFF;

    typedef enum logic [2:0] {
        K_ECHO   = 3'd0,
        K_DONE   = 3'd1,
        K_ERROR  = 3'd2,
        K_STAT1  = 3'd3,
        K_STAT2  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] echo;
        logic [7:0] stat0;
        logic [7:0] stat1;
        logic [7:0] relay;
    } t_desc;

    function automatic logic [7:0] f_hex_char(input logic [3:0] nib);
        if (nib <= 4'd9) begin
            return C_ZERO + {4'h0, nib};
        end
        return C_UPPER + {4'h0, nib};
    endfunction

    function automatic logic [4:0] f_hex_value(input logic [7:0] c);
        logic [7:0] d;
        logic [7:0] e;
        d = c - C_ZERO;
        e = d - 8'd7;
        if (d <= 8'd9) begin
            return {1'b1, d[3:0]};
        end
        if (d >= HEX_LO && d <= HEX_HI) begin
            return {1'b1, e[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic logic [3:0] f_resp_len(input t_kind kind);
        case (kind)
            K_ECHO:  return 4'd1;
            K_DONE:  return 4'd3;
            K_ERROR: return 4'd10;
            K_STAT1: return 4'd6;
            K_STAT2: return 4'd7;
            default: return 4'd1;
        endcase
    endfunction

    function automatic logic [7:0] f_resp_byte(input t_desc d, input logic [3:0] idx);
        logic [7:0] b;
        b = C_LF;
        case (idx)
            4'd0: b = d.echo;
            4'd1: b = C_CR;
            4'd2: b = C_LF;
            default: begin
                case (d.kind)
                    K_ERROR: begin
                        case (idx)
                            4'd3:    b = C_E;
                            4'd4:    b = C_R;
                            4'd5:    b = C_R;
                            4'd6:    b = C_O;
                            4'd7:    b = C_R;
                            4'd8:    b = C_CR;
                            default: b = C_LF;
                        endcase
                    end
                    K_STAT1: begin
                        case (idx)
                            4'd3:    b = d.stat0;
                            4'd4:    b = C_CR;
                            default: b = C_LF;
                        endcase
                    end
                    K_STAT2: begin
                        case (idx)
                            4'd3:    b = d.stat0;
                            4'd4:    b = d.stat1;
                            4'd5:    b = C_CR;
                            default: b = C_LF;
                        endcase
                    end
                    default: b = C_LF;
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// ----- sv/arci_front.sv -----
module arci_front import arci_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [7:0] i_rx_byte,
    output logic       o_wr_en,
    output t_desc      o_wr_desc
);

    logic [7:0] r_first;
    logic [7:0] r_second;
    logic [1:0] r_count;
    logic [7:0] r_relay;
    logic [7:0] n_first;
    logic [7:0] n_second;
    logic [1:0] n_count;
    logic [7:0] n_relay;

    logic       accept;
    logic       complete;
    logic [7:0] second;
    logic [7:0] digit;
    logic [7:0] bitmask;
    logic [7:0] on_mask;
    logic [4:0] hv_hi;
    logic [4:0] hv_lo;
    t_desc      desc;

    assign accept  = i_push && !i_full;
    assign on_mask = ~r_relay;

    always_comb begin
        n_first  = r_first;
        n_second = r_second;
        n_count  = r_count;
        n_relay  = r_relay;
        complete = 1'b0;
        second   = r_second;
        case (r_count)
            2'd1: begin
                n_second = i_rx_byte;
                second   = i_rx_byte;
                if (r_first == C_R) begin
                    n_count = 2'd2;
                end else begin
                    complete = 1'b1;
                    n_count  = 2'd0;
                end
            end
            2'd2: begin
                complete = 1'b1;
                n_count  = 2'd0;
            end
            default: begin
                n_first = i_rx_byte;
                n_count = 2'd1;
            end
        endcase

        digit   = second - C_ZERO;
        bitmask = (digit == 8'd0) ? 8'd0 : 8'(8'd1 << digit[2:0] - 3'd1);
        hv_hi   = f_hex_value(second);
        hv_lo   = f_hex_value(i_rx_byte);

        desc.kind  = K_ECHO;
        desc.echo  = i_rx_byte;
        desc.stat0 = C_ZERO;
        desc.stat1 = C_ZERO;

        if (complete) begin
            desc.kind = K_ERROR;
            if (r_first == C_R) begin
                if (hv_hi[4] && hv_lo[4]) begin
                    desc.kind = K_DONE;
                    n_relay   = ~{hv_hi[3:0], hv_lo[3:0]};
                end
            end else if (digit <= 8'd8) begin
                case (r_first)
                    C_N: begin
                        desc.kind = K_DONE;
                        n_relay   = (digit == 8'd0) ? 8'h00 : (r_relay & ~bitmask);
                    end
                    C_F: begin
                        desc.kind = K_DONE;
                        n_relay   = (digit == 8'd0) ? ALL_OFF : (r_relay | bitmask);
                    end
                    C_T: begin
                        desc.kind = K_DONE;
                        n_relay   = (digit == 8'd0) ? ~r_relay : (r_relay ^ bitmask);
                    end
                    C_S: begin
                        if (digit == 8'd0) begin
                            desc.kind  = K_STAT2;
                            desc.stat0 = f_hex_char(on_mask[7:4]);
                            desc.stat1 = f_hex_char(on_mask[3:0]);
                        end else begin
                            desc.kind  = K_STAT1;
                            desc.stat0 = ((on_mask & bitmask) != 8'd0) ? C_ONE : C_ZERO;
                        end
                    end
                    default: desc.kind = K_ERROR;
                endcase
            end
        end
        desc.relay = n_relay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= 8'd0;
            r_second <= 8'd0;
            r_count  <= 2'd0;
            r_relay  <= ALL_OFF;
        end else if (accept) begin
            r_first  <= n_first;
            r_second <= n_second;
            r_count  <= n_count;
            r_relay  <= n_relay;
        end
    end

    assign o_wr_en   = accept;
    assign o_wr_desc = desc;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("command character count out of range");

    a_third_only_r: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == 2'd2 |-> r_first == C_R)
        else $error("third character gathered for a non-R command");

endmodule

// ----- sv/arci_queue.sv -----
module arci_queue import arci_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr_en,
    input  t_desc i_wr_desc,
    input  logic  i_rd_en,
    output t_desc o_rd_desc,
    output logic  o_full,
    output logic  o_empty
);

    t_desc               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_count;

    assign o_full    = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_desc = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_wr_en, i_rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue fill above depth");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rd_en |-> !o_empty)
        else $error("read from empty queue");

endmodule

// ----- sv/arci_back.sv -----
module arci_back import arci_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_desc      i_rd_desc,
    input  logic       i_q_empty,
    output logic       o_rd_en,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_tx_byte,
    output logic       o_last,
    output logic [7:0] o_relay_state
);

    logic       r_out_valid;
    logic [3:0] r_idx;
    logic [7:0] r_tx;
    logic       r_last;
    logic [7:0] r_relay;

    logic       advance;
    logic       at_end;
    logic [3:0] len;

    assign len     = f_resp_len(i_rd_desc.kind);
    assign at_end  = (r_idx == len - 4'd1);
    assign advance = !i_q_empty && (!r_out_valid || i_pop);
    assign o_rd_en = advance && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 4'd0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_idx       <= at_end ? 4'd0 : r_idx + 4'd1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_tx    <= f_resp_byte(i_rd_desc, r_idx);
            r_last  <= at_end;
            r_relay <= i_rd_desc.relay;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_tx_byte     = r_tx;
    assign o_last        = r_last;
    assign o_relay_state = r_relay;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_empty |-> r_idx < len)
        else $error("response index beyond response length");

    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |=> r_idx == 4'd0 && r_last && r_out_valid)
        else $error("response sequencer did not restart after final byte");

endmodule

// ----- sv/ascii_relay_command_interpreter_unit.sv -----
// channel   | handshake              | payload
// ----------+------------------------+-----------------------------------
// command   | push / full            | i_rx_byte
// response  | empty / pop            | o_tx_byte, o_last, o_relay_state
//
// Each received byte is decoded in the cycle it is accepted and queued as one
// response request; the back end sends one byte per cycle while the response
// side pops; a request is 1, 3, 6, 7 or 10 bytes, set by the byte sequencer.
// A four-entry request queue lets the command side run ahead of a stalled
// response side; full rises only when that queue is full.
// Synchronous active-low reset: relays all off, command gathering restarts.
module ascii_relay_command_interpreter_unit import arci_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_tx_byte,
    output logic       o_last,
    output logic [7:0] o_relay_state
);

    logic  wr_en;
    t_desc wr_desc;
    logic  rd_en;
    t_desc rd_desc;
    logic  q_empty;

    arci_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_full    (full),
        .i_rx_byte (i_rx_byte),
        .o_wr_en   (wr_en),
        .o_wr_desc (wr_desc)
    );

    arci_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_desc (wr_desc),
        .i_rd_en   (rd_en),
        .o_rd_desc (rd_desc),
        .o_full    (full),
        .o_empty   (q_empty)
    );

    arci_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rd_desc     (rd_desc),
        .i_q_empty     (q_empty),
        .o_rd_en       (rd_en),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_tx_byte     (o_tx_byte),
        .o_last        (o_last),
        .o_relay_state (o_relay_state)
    );

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import arci_pkg::*;

    typedef struct packed {
        logic [7:0] tx;
        logic       last;
        logic [7:0] relay;
    } t_tx_char;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_rx_byte;
    logic       empty;
    logic       pop;
    logic [7:0] o_tx_byte;
    logic       o_last;
    logic [7:0] o_relay_state;

    t_tx_char    tx_expected[$];
    logic [7:0]  cmd_first;
    logic [7:0]  cmd_second;
    logic [1:0]  cmd_count;
    logic [7:0]  relay_port_model;

    int unsigned errors;
    int unsigned bytes_sent;
    int unsigned chars_checked;
    int unsigned full_stalls;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned rx_hold_cycles;

    ascii_relay_command_interpreter_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_rx_byte     (i_rx_byte),
        .empty         (empty),
        .pop           (pop),
        .o_tx_byte     (o_tx_byte),
        .o_last        (o_last),
        .o_relay_state (o_relay_state)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    initial begin
        #5ms;
        $display("Timeout at %0t", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [7:0] hex_digit_char(input logic [3:0] nib);
        return (nib < 4'd10) ? C_ZERO + {4'h0, nib} : C_UPPER + {4'h0, nib};
    endfunction

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= C_ZERO && c <= 8'h39) begin
            return {1'b1, c[3:0]};
        end
        if (c >= 8'h41 && c <= C_F) begin
            return {1'b1, c[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    task automatic predict_response(input logic [7:0] rx);
        logic [7:0] resp[$];
        logic [7:0] stat[$];
        logic       done;
        logic       err;
        logic       is_status;
        logic [7:0] third;
        logic [7:0] digit;
        logic [7:0] bitm;
        logic [7:0] on_mask;
        logic [7:0] next_port;
        logic [4:0] hi;
        logic [4:0] lo;
        t_tx_char   c;
        resp = {};
        stat = {};
        resp.push_back(rx);
        done = 1'b0;
        third = 8'h00;
        case (cmd_count)
            2'd0: begin
                cmd_first = rx;
                cmd_count = 2'd1;
            end
            2'd1: begin
                cmd_second = rx;
                if (cmd_first == C_R) begin
                    cmd_count = 2'd2;
                end else begin
                    done = 1'b1;
                    cmd_count = 2'd0;
                end
            end
            default: begin
                third = rx;
                done = 1'b1;
                cmd_count = 2'd0;
            end
        endcase
        if (done) begin
            err = 1'b1;
            is_status = 1'b0;
            next_port = relay_port_model;
            on_mask = ~relay_port_model;
            if (cmd_first != C_R) begin
                digit = cmd_second - C_ZERO;
                if (digit <= 8'd8) begin
                    bitm = (digit == 8'd0) ? 8'h00 : 8'h01 << (digit - 8'd1);
                    err = 1'b0;
                    case (cmd_first)
                        C_N: next_port = (digit == 8'd0) ? 8'h00 : relay_port_model & ~bitm;
                        C_F: next_port = (digit == 8'd0) ? ALL_OFF : relay_port_model | bitm;
                        C_T: next_port = (digit == 8'd0) ? ~relay_port_model
                                                         : relay_port_model ^ bitm;
                        C_S: begin
                            is_status = 1'b1;
                            if (digit == 8'd0) begin
                                stat.push_back(hex_digit_char(on_mask[7:4]));
                                stat.push_back(hex_digit_char(on_mask[3:0]));
                            end else begin
                                stat.push_back((on_mask & bitm) != 8'h00 ? C_ONE : C_ZERO);
                            end
                        end
                        default: err = 1'b1;
                    endcase
                end
            end else begin
                hi = hex_nibble(cmd_second);
                lo = hex_nibble(third);
                if (hi[4] && lo[4]) begin
                    next_port = ~{hi[3:0], lo[3:0]};
                    err = 1'b0;
                end
            end
            resp.push_back(C_CR);
            resp.push_back(C_LF);
            if (err) begin
                resp.push_back(C_E);
                resp.push_back(C_R);
                resp.push_back(C_R);
                resp.push_back(C_O);
                resp.push_back(C_R);
                resp.push_back(C_CR);
                resp.push_back(C_LF);
            end else if (is_status) begin
                foreach (stat[k]) begin
                    resp.push_back(stat[k]);
                end
                resp.push_back(C_CR);
                resp.push_back(C_LF);
            end else begin
                relay_port_model = next_port;
            end
        end
        foreach (resp[k]) begin
            c.tx = resp[k];
            c.last = (k == resp.size() - 1);
            c.relay = relay_port_model;
            tx_expected.push_back(c);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push = 1'b1;
        i_rx_byte = b;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        predict_response(b);
        bytes_sent++;
        @(negedge i_clk);
        push = 1'b0;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    task automatic wait_drain();
        while (tx_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (15) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random_command();
        logic [7:0] letters[5];
        logic [7:0] l;
        int unsigned pick;
        letters = '{C_N, C_F, C_T, C_S, C_R};
        l = letters[$urandom_range(4, 0)];
        if ($urandom_range(99, 0) < 80) begin
            send_byte(l);
            if (l == C_R) begin
                send_byte(hex_digit_char(4'($urandom_range(15, 0))));
                send_byte(hex_digit_char(4'($urandom_range(15, 0))));
            end else begin
                send_byte(C_ZERO + 8'($urandom_range(8, 0)));
            end
        end else begin
            pick = $urandom_range(4, 0);
            case (pick)
                0: send_byte(8'($urandom_range(255, 0)));
                1: begin
                    send_byte(8'($urandom_range(255, 0)));
                    send_byte(8'($urandom_range(255, 0)));
                end
                2: begin
                    send_byte(letters[$urandom_range(3, 0)]);
                    send_byte(8'($urandom_range(255, 0)));
                end
                3: begin
                    send_byte(C_R);
                    send_byte(8'($urandom_range(255, 0)));
                    send_byte(8'($urandom_range(255, 0)));
                end
                default: begin
                    send_byte(C_R);
                    send_byte(8'h61 + 8'($urandom_range(5, 0)));
                    send_byte(hex_digit_char(4'($urandom_range(15, 0))));
                end
            endcase
        end
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_text("N0S0F3S3T5S5");
        send_text("RA5Ra5X1N9");
        send_byte(8'hFF);
        send_byte(8'h00);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int unsigned n_bytes, input int unsigned s_pct,
                                       input int unsigned r_pct);
        int unsigned stop_at;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            send_random_command();
        end
        wait_drain();
    endtask

    task automatic test_full_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rx_hold_cycles = 300;
        repeat (8) send_text("S0");
        send_text("T0S0");
        wait_drain();
    endtask

    // hold the receiver while a stall is requested, else pop at random
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                pop = 1'b0;
            end else begin
                pop = ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_tx_char exp_c;
        if (i_rst_n) begin
            if (push && full) begin
                full_stalls++;
            end
            if (pop && !empty) begin
                chars_checked++;
                if (tx_expected.size() == 0) begin
                    $display("%0t: unexpected response tx=%h last=%b relay=%h",
                             $time, o_tx_byte, o_last, o_relay_state);
                    errors++;
                end else begin
                    exp_c = tx_expected.pop_front();
                    if (o_tx_byte !== exp_c.tx) begin
                        $display("%0t: tx_byte expected %h actual %h",
                                 $time, exp_c.tx, o_tx_byte);
                        errors++;
                    end
                    if (o_last !== exp_c.last) begin
                        $display("%0t: last expected %b actual %b",
                                 $time, exp_c.last, o_last);
                        errors++;
                    end
                    if (o_relay_state !== exp_c.relay) begin
                        $display("%0t: relay_state expected %h actual %h",
                                 $time, exp_c.relay, o_relay_state);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        errors = 0;
        bytes_sent = 0;
        chars_checked = 0;
        full_stalls = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rx_hold_cycles = 0;
        cmd_first = 8'h00;
        cmd_second = 8'h00;
        cmd_count = 2'd0;
        relay_port_model = ALL_OFF;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_rx_byte = 8'h00;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_traffic(100, 33, 87);
        test_random_traffic(100, 87, 33);
        test_full_stall();
        test_random_traffic(100, 0, 0);

        $display("Sent %0d command bytes, checked %0d response characters,", bytes_sent,
                 chars_checked);
        $display("input held off by full for %0d cycles", full_stalls);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/arci_pkg.sv
sv/arci_front.sv
sv/arci_queue.sv
sv/arci_back.sv
sv/ascii_relay_command_interpreter_unit.sv
dv/testbench.sv
